[rtl/pal_pkg.sv]
// Shared constants and codes for the positional array list.
package pal_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int COUNT_W  = 5;
  localparam int POS_W    = 5;
  localparam int DATA_W   = 32;

  typedef enum logic [1:0] {
    MODE_INSERT   = 2'd0,
    MODE_REMOVE   = 2'd1,
    MODE_READ     = 2'd2,
    MODE_CONTAINS = 2'd3
  } pal_mode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2
  } pal_status_e;

endpackage

[rtl/pal_if.sv]
// Valid/ready channel interfaces for list operations and their results.
interface pal_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          mode;
  logic [pal_pkg::POS_W-1:0]           position;
  logic signed [pal_pkg::DATA_W-1:0]   value;

  modport source (output valid, output mode, output position, output value, input ready);
  modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

interface pal_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pal_pkg::DATA_W-1:0]   read_value;
  logic                                found;
  logic [1:0]                          status;
  logic [pal_pkg::COUNT_W-1:0]         count;
  logic                                is_empty;
  logic                                ascending;

  modport source (output valid, output read_value, output found, output status,
                  output count, output is_empty, output ascending, input ready);
  modport sink   (input valid, input read_value, input found, input status,
                  input count, input is_empty, input ascending, output ready);
endinterface

[rtl/positional_array_list_unit.sv]
// Top level of the positional array list: operation register, list update, result register.
//
//   channel  | dir | payload                                            | transfer when
//   ---------+-----+----------------------------------------------------+----------------
//   in_i     | in  | mode, position, value                              | valid && ready
//   out_o    | out | read_value, found, status, count, is_empty, ascend | valid && ready
//
// An operation is captured in the operation register; from there the list
// update, lookup and order check run as one combinational pass and land in
// the result register together with the new list state. One operation per
// cycle is sustained while out_o is not stalled, set by that single combinational pass.
// Reset clears the count and both valid flags; the entries are not reset and
// only entries below the count are ever looked at.
// A stall on out_o holds the result, then the pending operation, then in_i.
module positional_array_list_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  pal_in_if.sink          in_i,
  pal_out_if.source       out_o
);

  // Operation register
  logic                                   op_valid_q;
  pal_pkg::pal_mode_e                     mode_q;
  logic [pal_pkg::POS_W-1:0]              pos_q;
  logic signed [pal_pkg::DATA_W-1:0]      value_q;

  // List state
  logic signed [pal_pkg::DATA_W-1:0]      entries_q [pal_pkg::CAPACITY];
  logic signed [pal_pkg::DATA_W-1:0]      entries_d [pal_pkg::CAPACITY];
  logic [pal_pkg::COUNT_W-1:0]            count_q, count_d;

  // Result register
  logic                                   res_valid_q;
  logic signed [pal_pkg::DATA_W-1:0]      read_q, read_d;
  logic                                   found_q, found_d;
  pal_pkg::pal_status_e                   status_q, status_d;
  logic [pal_pkg::COUNT_W-1:0]            res_count_q;
  logic                                   asc_q, asc_d;

  logic                                   res_load;
  logic                                   op_adv;
  logic                                   full;
  logic                                   ins_pos_ok;
  logic                                   pos_ok;
  logic [pal_pkg::IDX_W-1:0]              idx;

  // Handshake: the result slot frees on a transfer, the operation slot frees
  // when its result moves into the result slot.
  assign res_load   = !res_valid_q || out_o.ready;
  assign op_adv     = op_valid_q && res_load;
  assign in_i.ready = !op_valid_q || res_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      op_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      mode_q  <= pal_pkg::pal_mode_e'(in_i.mode);
      pos_q   <= in_i.position;
      value_q <= in_i.value;
    end
  end

  // Position checks; full is tested ahead of the position on insert.
  assign full       = count_q >= pal_pkg::COUNT_W'(pal_pkg::CAPACITY);
  assign pos_ok     = (pos_q != '0) && (pos_q <= count_q);
  assign ins_pos_ok = (pos_q != '0) &&
                      ({1'b0, pos_q} <= ({1'b0, count_q} + (pal_pkg::COUNT_W+1)'(1)));
  assign idx        = pal_pkg::IDX_W'(pos_q - pal_pkg::POS_W'(1));

  // One pass: shift up for insert, shift down for remove, lookup and search.
  always_comb begin
    entries_d = entries_q;
    count_d   = count_q;
    status_d  = pal_pkg::ST_OK;
    read_d    = '0;
    found_d   = 1'b0;
    unique case (mode_q)
      pal_pkg::MODE_INSERT: begin
        if (full) begin
          status_d = pal_pkg::ST_FULL;
        end else if (!ins_pos_ok) begin
          status_d = pal_pkg::ST_BADPOS;
        end else begin
          for (int i = 1; i < pal_pkg::CAPACITY; i++) begin
            if (pal_pkg::IDX_W'(i) > idx) entries_d[i] = entries_q[i-1];
          end
          for (int i = 0; i < pal_pkg::CAPACITY; i++) begin
            if (pal_pkg::IDX_W'(i) == idx) entries_d[i] = value_q;
          end
          count_d = count_q + pal_pkg::COUNT_W'(1);
        end
      end
      pal_pkg::MODE_REMOVE: begin
        if (!pos_ok) begin
          status_d = pal_pkg::ST_BADPOS;
        end else begin
          for (int i = 0; i < pal_pkg::CAPACITY - 1; i++) begin
            if (pal_pkg::IDX_W'(i) >= idx) entries_d[i] = entries_q[i+1];
          end
          count_d = count_q - pal_pkg::COUNT_W'(1);
        end
      end
      pal_pkg::MODE_READ: begin
        if (!pos_ok) begin
          status_d = pal_pkg::ST_BADPOS;
        end else begin
          read_d = entries_q[idx];
        end
      end
      pal_pkg::MODE_CONTAINS: begin
        for (int i = 0; i < pal_pkg::CAPACITY; i++) begin
          if ((pal_pkg::COUNT_W'(i) < count_q) && (entries_q[i] == value_q)) found_d = 1'b1;
        end
      end
      default: begin
        status_d = pal_pkg::ST_OK;
      end
    endcase
  end

  // Order check on the list as it stands after the operation.
  always_comb begin
    asc_d = 1'b1;
    for (int i = 1; i < pal_pkg::CAPACITY; i++) begin
      if ((pal_pkg::COUNT_W'(i) < count_d) && !(entries_d[i-1] < entries_d[i])) asc_d = 1'b0;
    end
  end

  // Commit list state together with the result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (op_adv) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_adv) begin
      entries_q <= entries_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= op_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_adv) begin
      read_q      <= read_d;
      found_q     <= found_d;
      status_q    <= status_d;
      res_count_q <= count_d;
      asc_q       <= asc_d;
    end
  end

  assign out_o.valid      = res_valid_q;
  assign out_o.read_value = read_q;
  assign out_o.found      = found_q;
  assign out_o.status     = status_q;
  assign out_o.count      = res_count_q;
  assign out_o.is_empty   = (res_count_q == '0);
  assign out_o.ascending  = asc_q;

`ifndef SYNTHESIS
  // The count never grows past the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= pal_pkg::COUNT_W'(pal_pkg::CAPACITY))
    else $error("list count above capacity");

  // A full report only comes from a full list.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status == pal_pkg::ST_FULL)) |->
    (out_o.count == pal_pkg::COUNT_W'(pal_pkg::CAPACITY)))
    else $error("full status with list not full");

  // A rejected operation leaves the count alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_adv && (status_d != pal_pkg::ST_OK)) |=> (count_q == $past(count_q)))
    else $error("rejected operation changed the count");

  // Without an advance the list state holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !op_adv |=> $stable(count_q))
    else $error("count moved without an operation");
`endif

endmodule
